// ----- rtl/core/hsea_pkg.sv -----
package hsea_pkg;

  // default widths
  localparam int unsigned DEF_CHANNEL_BITS   = 16;
  localparam int unsigned DEF_GAIN_FRAC_BITS = 12;

  // fixed field widths
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned HUE_FRAC  = 16;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAT_GAIN = 8'd0,
    CFG_EXP_GAIN = 8'd1
  } cfg_reg_e;

  // hue sextants, also used as the hue base of the dominant channel
  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } hue_sector_e;

  // per-pixel flags from the front stage
  typedef struct packed {
    logic zero_max;
    logic zero_delta;
    logic hue_neg;
  } hsv_flags_t;

  localparam int unsigned FLAGS_W = $bits(hsv_flags_t);

endpackage

// ----- rtl/core/hsv_saturation_exposure_adjust_unit.sv -----
// pipeline: front stage register, then the divider stages, then the back stages
// throughput: one word per cycle unless the output stalls; the two dividers retire one quotient bit per stage
// the whole pipeline holds while a finished word waits and out_ready_i is low
// reset: asynchronous, active low; clears all valid bits, both gains return to 4096
module hsv_saturation_exposure_adjust_unit #(
  parameter int unsigned CHANNEL_BITS   = hsea_pkg::DEF_CHANNEL_BITS,
  parameter int unsigned GAIN_FRAC_BITS = hsea_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [hsea_pkg::PIX_W-1:0]       red_in_i,
  input  logic [hsea_pkg::PIX_W-1:0]       green_in_i,
  input  logic [hsea_pkg::PIX_W-1:0]       blue_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [hsea_pkg::PIX_W-1:0]       red_out_o,
  output logic [hsea_pkg::PIX_W-1:0]       green_out_o,
  output logic [hsea_pkg::PIX_W-1:0]       blue_out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hsea_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hsea_pkg::GAIN_W-1:0]      cfg_data_i
);
  import hsea_pkg::*;

  localparam int unsigned N      = CHANNEL_BITS;
  localparam int unsigned QW     = (N > HUE_FRAC + 1) ? N : HUE_FRAC + 1;
  localparam int unsigned REM_W  = N + QW;
  localparam int unsigned SIDE_W = N + 3 + FLAGS_W;

  logic               en;
  logic [GAIN_W-1:0]  sat_gain_q, exp_gain_q;

  // pipeline advances unless the output word is stalled
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_gain_q <= GAIN_RESET;
      exp_gain_q <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SAT_GAIN: sat_gain_q <= cfg_data_i;
        CFG_EXP_GAIN: exp_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: max, min, hue terms
  logic               fr_valid;
  logic [N-1:0]       fr_max, fr_delta;
  logic [2*N-1:0]     fr_s_num;
  logic [N+15:0]      fr_h_num;
  hue_sector_e        fr_base;
  hsv_flags_t         fr_flags;

  hsea_front #(
    .CHANNEL_BITS (N)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .red_i   (N'(red_in_i)),
    .green_i (N'(green_in_i)),
    .blue_i  (N'(blue_in_i)),
    .valid_o (fr_valid),
    .max_o   (fr_max),
    .delta_o (fr_delta),
    .s_num_o (fr_s_num),
    .h_num_o (fr_h_num),
    .base_o  (fr_base),
    .flags_o (fr_flags)
  );

  // saturation and hue dividers
  logic               dv_valid;
  logic [QW-1:0]      dv_quot_s, dv_quot_h;
  logic [SIDE_W-1:0]  dv_side_in, dv_side;
  logic [N-1:0]       dv_max;
  hue_sector_e        dv_base;
  hsv_flags_t         dv_flags;

  assign dv_side_in = {fr_max, fr_base, fr_flags};

  hsea_div_pipe #(
    .DEN_W  (N),
    .QUOT_W (QW),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (fr_valid),
    .num_a_i  (REM_W'(fr_s_num)),
    .den_a_i  (fr_max),
    .num_b_i  (REM_W'(fr_h_num)),
    .den_b_i  (fr_delta),
    .side_i   (dv_side_in),
    .valid_o  (dv_valid),
    .quot_a_o (dv_quot_s),
    .quot_b_o (dv_quot_h),
    .side_o   (dv_side)
  );

  assign dv_max   = dv_side[SIDE_W-1 -: N];
  assign dv_base  = hue_sector_e'(dv_side[FLAGS_W+2:FLAGS_W]);
  assign dv_flags = hsv_flags_t'(dv_side[FLAGS_W-1:0]);

  // gains, back conversion, clamp
  hsea_back #(
    .CHANNEL_BITS   (N),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dv_valid),
    .max_i      (dv_max),
    .s_raw_i    (dv_quot_s[N-1:0]),
    .h_mag_i    (dv_quot_h[HUE_FRAC:0]),
    .base_i     (dv_base),
    .flags_i    (dv_flags),
    .sat_gain_i (sat_gain_q),
    .exp_gain_i (exp_gain_q),
    .valid_o    (out_valid_o),
    .red_o      (red_out_o),
    .green_o    (green_out_o),
    .blue_o     (blue_out_o)
  );

endmodule

// ----- rtl/core/hsea_front.sv -----
module hsea_front #(
  parameter int unsigned CHANNEL_BITS = hsea_pkg::DEF_CHANNEL_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [CHANNEL_BITS-1:0]          red_i,
  input  logic [CHANNEL_BITS-1:0]          green_i,
  input  logic [CHANNEL_BITS-1:0]          blue_i,
  output logic                             valid_o,
  output logic [CHANNEL_BITS-1:0]          max_o,
  output logic [CHANNEL_BITS-1:0]          delta_o,
  output logic [2*CHANNEL_BITS-1:0]        s_num_o,
  output logic [CHANNEL_BITS+15:0]         h_num_o,
  output hsea_pkg::hue_sector_e            base_o,
  output hsea_pkg::hsv_flags_t             flags_o
);
  import hsea_pkg::*;

  localparam int unsigned N = CHANNEL_BITS;

  logic [N-1:0]     mx, mn, delta, pos, neg, mag;
  hue_sector_e      base;
  hsv_flags_t       flags;
  logic             valid_q;
  logic [N-1:0]     max_q, delta_q;
  logic [2*N-1:0]   s_num_q;
  logic [N+15:0]    h_num_q;
  hue_sector_e      base_q;
  hsv_flags_t       flags_q;

  // max, min and spread
  always_comb begin
    mx = (red_i > green_i) ? ((red_i > blue_i) ? red_i : blue_i)
                           : ((green_i > blue_i) ? green_i : blue_i);
    mn = (red_i < green_i) ? ((red_i < blue_i) ? red_i : blue_i)
                           : ((green_i < blue_i) ? green_i : blue_i);
    delta = mx - mn;
  end

  // dominant channel picks hue base and difference terms
  always_comb begin
    if (red_i == mx) begin
      base = SECT_RED_YEL;
      pos  = green_i;
      neg  = blue_i;
    end else if (green_i == mx) begin
      base = SECT_GRN_CYN;
      pos  = blue_i;
      neg  = red_i;
    end else begin
      base = SECT_BLU_MAG;
      pos  = red_i;
      neg  = green_i;
    end
    flags.hue_neg    = (pos < neg);
    flags.zero_max   = (mx == '0);
    flags.zero_delta = (delta == '0);
    mag = flags.hue_neg ? (neg - pos) : (pos - neg);
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      max_q   <= mx;
      delta_q <= delta;
      s_num_q <= {delta, {N{1'b0}}} - {{N{1'b0}}, delta};
      h_num_q <= {mag, 16'h0000};
      base_q  <= base;
      flags_q <= flags;
    end
  end

  assign valid_o = valid_q;
  assign max_o   = max_q;
  assign delta_o = delta_q;
  assign s_num_o = s_num_q;
  assign h_num_o = h_num_q;
  assign base_o  = base_q;
  assign flags_o = flags_q;

endmodule

// ----- rtl/core/hsea_div_pipe.sv -----
module hsea_div_pipe #(
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned QUOT_W = 17,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [DEN_W+QUOT_W-1:0]   num_a_i,
  input  logic [DEN_W-1:0]          den_a_i,
  input  logic [DEN_W+QUOT_W-1:0]   num_b_i,
  input  logic [DEN_W-1:0]          den_b_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [QUOT_W-1:0]         quot_a_o,
  output logic [QUOT_W-1:0]         quot_b_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int unsigned REM_W = DEN_W + QUOT_W;

  logic              valid_q [QUOT_W];
  logic [REM_W-1:0]  rem_a_q [QUOT_W];
  logic [REM_W-1:0]  rem_b_q [QUOT_W];
  logic [DEN_W-1:0]  den_a_q [QUOT_W];
  logic [DEN_W-1:0]  den_b_q [QUOT_W];
  logic [QUOT_W-1:0] quot_a_q [QUOT_W];
  logic [QUOT_W-1:0] quot_b_q [QUOT_W];
  logic [SIDE_W-1:0] side_q [QUOT_W];

  // one quotient bit per stage, both lanes in step
  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic              vin;
    logic [REM_W-1:0]  ra_in, rb_in, sha, shb, ra_d, rb_d;
    logic [DEN_W-1:0]  da_in, db_in;
    logic [QUOT_W-1:0] qa_in, qb_in;
    logic [SIDE_W-1:0] sd_in;
    logic              ge_a, ge_b;

    if (k == 0) begin : g_first
      assign vin   = valid_i;
      assign ra_in = num_a_i;
      assign rb_in = num_b_i;
      assign da_in = den_a_i;
      assign db_in = den_b_i;
      assign qa_in = '0;
      assign qb_in = '0;
      assign sd_in = side_i;
    end else begin : g_next
      assign vin   = valid_q[k-1];
      assign ra_in = rem_a_q[k-1];
      assign rb_in = rem_b_q[k-1];
      assign da_in = den_a_q[k-1];
      assign db_in = den_b_q[k-1];
      assign qa_in = quot_a_q[k-1];
      assign qb_in = quot_b_q[k-1];
      assign sd_in = side_q[k-1];
    end

    // trial subtract of the aligned divisor
    always_comb begin
      sha  = REM_W'(da_in) << (QUOT_W - 1 - k);
      shb  = REM_W'(db_in) << (QUOT_W - 1 - k);
      ge_a = (ra_in >= sha);
      ge_b = (rb_in >= shb);
      ra_d = ge_a ? (ra_in - sha) : ra_in;
      rb_d = ge_b ? (rb_in - shb) : rb_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_a_q[k]  <= ra_d;
        rem_b_q[k]  <= rb_d;
        den_a_q[k]  <= da_in;
        den_b_q[k]  <= db_in;
        quot_a_q[k] <= {qa_in[QUOT_W-2:0], ge_a};
        quot_b_q[k] <= {qb_in[QUOT_W-2:0], ge_b};
        side_q[k]   <= sd_in;
      end
    end
  end

  assign valid_o  = valid_q[QUOT_W-1];
  assign quot_a_o = quot_a_q[QUOT_W-1];
  assign quot_b_o = quot_b_q[QUOT_W-1];
  assign side_o   = side_q[QUOT_W-1];

endmodule

// ----- rtl/core/hsea_back.sv -----
module hsea_back #(
  parameter int unsigned CHANNEL_BITS   = hsea_pkg::DEF_CHANNEL_BITS,
  parameter int unsigned GAIN_FRAC_BITS = hsea_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [CHANNEL_BITS-1:0]          max_i,
  input  logic [CHANNEL_BITS-1:0]          s_raw_i,
  input  logic [hsea_pkg::HUE_FRAC:0]      h_mag_i,
  input  hsea_pkg::hue_sector_e            base_i,
  input  hsea_pkg::hsv_flags_t             flags_i,
  input  logic [hsea_pkg::GAIN_W-1:0]      sat_gain_i,
  input  logic [hsea_pkg::GAIN_W-1:0]      exp_gain_i,
  output logic                             valid_o,
  output logic [hsea_pkg::PIX_W-1:0]       red_o,
  output logic [hsea_pkg::PIX_W-1:0]       green_o,
  output logic [hsea_pkg::PIX_W-1:0]       blue_o
);
  import hsea_pkg::*;

  localparam int unsigned N   = CHANNEL_BITS;
  localparam int unsigned SVW = N + 4;
  localparam int unsigned PW  = N + GAIN_W;
  localparam int unsigned NW  = SVW + N;

  localparam logic [PW-1:0]  SV_CAP  = {{(GAIN_W-4){1'b0}}, {SVW{1'b1}}};
  localparam logic [SVW:0]   FULL_SV = {5'b00000, {N{1'b1}}};
  localparam logic [NW-1:0]  FULL_NW = {{SVW{1'b0}}, {N{1'b1}}};
  localparam logic [NW-1:0]  FULL_SQ = FULL_NW * FULL_NW;
  localparam logic signed [19:0] HUE_WRAP = 20'sd393216;
  localparam logic [HUE_FRAC:0]  HUE_ONE  = 17'h10000;

  // divide by full scale, clamped at full scale
  function automatic logic [N-1:0] scale_down(input logic [NW-1:0] x);
    logic [NW:0] y;
    begin
      y = {1'b0, x} + {1'b0, (x >> N)} + {{NW{1'b0}}, 1'b1};
      if (x >= FULL_SQ) begin
        scale_down = {N{1'b1}};
      end else begin
        scale_down = y[2*N-1:N];
      end
    end
  endfunction

  // full scale minus a term, floored at zero
  function automatic logic [N-1:0] comp_pos(input logic [SVW:0] x);
    logic [SVW:0] d;
    begin
      d = FULL_SV - x;
      comp_pos = (x >= FULL_SV) ? '0 : d[N-1:0];
    end
  endfunction

  // stage 1: hue assembly and gain products
  logic              st1_valid_q;
  logic [PW-1:0]     ps1_q, pv1_q;
  hue_sector_e       sec1_q;
  logic [15:0]       f1_q;
  logic [N-1:0]      s_val;
  logic signed [19:0] h_base, h_sum, h_wrap;

  always_comb begin
    s_val  = flags_i.zero_max ? '0 : s_raw_i;
    h_base = $signed({1'b0, base_i, 16'h0000});
    if (flags_i.hue_neg) begin
      h_sum = h_base - $signed({3'b000, h_mag_i});
    end else begin
      h_sum = h_base + $signed({3'b000, h_mag_i});
    end
    if (flags_i.zero_delta) begin
      h_wrap = '0;
    end else if (h_sum < 0) begin
      h_wrap = h_sum + HUE_WRAP;
    end else begin
      h_wrap = h_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ps1_q  <= s_val * sat_gain_i;
      pv1_q  <= max_i * exp_gain_i;
      sec1_q <= hue_sector_e'(h_wrap[18:16]);
      f1_q   <= h_wrap[15:0];
    end
  end

  // stage 2: drop gain fraction and saturate
  logic              st2_valid_q;
  logic [SVW-1:0]    s2_q, v2_q;
  hue_sector_e       sec2_q;
  logic [15:0]       f2_q;
  logic [PW-1:0]     ps_sh, pv_sh;

  always_comb begin
    ps_sh = ps1_q >> GAIN_FRAC_BITS;
    pv_sh = pv1_q >> GAIN_FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q   <= (ps_sh > SV_CAP) ? SVW'(SV_CAP) : SVW'(ps_sh);
      v2_q   <= (pv_sh > SV_CAP) ? SVW'(SV_CAP) : SVW'(pv_sh);
      sec2_q <= sec1_q;
      f2_q   <= f1_q;
    end
  end

  // stage 3: saturation times hue fraction and its complement, complement term for p
  logic              st3_valid_q;
  logic [SVW+15:0]   sf3_q;
  logic [SVW+16:0]   st3_q;
  logic [N-1:0]      ap3_q;
  logic [SVW-1:0]    v3_q;
  hue_sector_e       sec3_q;
  logic              gray3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sf3_q   <= s2_q * f2_q;
      st3_q   <= s2_q * (HUE_ONE - {1'b0, f2_q});
      ap3_q   <= comp_pos({1'b0, s2_q});
      v3_q    <= v2_q;
      sec3_q  <= sec2_q;
      gray3_q <= (s2_q == '0);
    end
  end

  // stage 4: complement terms for q and t
  logic              st4_valid_q;
  logic [N-1:0]      ap4_q, aq4_q, at4_q;
  logic [SVW-1:0]    v4_q;
  hue_sector_e       sec4_q;
  logic              gray4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ap4_q   <= ap3_q;
      aq4_q   <= comp_pos({1'b0, sf3_q[SVW+15:16]});
      at4_q   <= comp_pos(st3_q[SVW+16:16]);
      v4_q    <= v3_q;
      sec4_q  <= sec3_q;
      gray4_q <= gray3_q;
    end
  end

  // stage 5: value products
  logic              st5_valid_q;
  logic [NW-1:0]     np5_q, nq5_q, nt5_q;
  logic [SVW-1:0]    v5_q;
  hue_sector_e       sec5_q;
  logic              gray5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      np5_q   <= v4_q * ap4_q;
      nq5_q   <= v4_q * aq4_q;
      nt5_q   <= v4_q * at4_q;
      v5_q    <= v4_q;
      sec5_q  <= sec4_q;
      gray5_q <= gray4_q;
    end
  end

  // stage 6: scale back, sextant select, output register
  logic              st6_valid_q;
  logic [PIX_W-1:0]  red_q, green_q, blue_q;
  logic [N-1:0]      pc, qc, tc, vc, ro, go, bo;

  always_comb begin
    pc = scale_down(np5_q);
    qc = scale_down(nq5_q);
    tc = scale_down(nt5_q);
    vc = ({1'b0, v5_q} > FULL_SV) ? {N{1'b1}} : v5_q[N-1:0];
    if (gray5_q) begin
      ro = vc; go = vc; bo = vc;
    end else begin
      case (sec5_q)
        SECT_RED_YEL: begin ro = vc; go = tc; bo = pc; end
        SECT_YEL_GRN: begin ro = qc; go = vc; bo = pc; end
        SECT_GRN_CYN: begin ro = pc; go = vc; bo = tc; end
        SECT_CYN_BLU: begin ro = pc; go = qc; bo = vc; end
        SECT_BLU_MAG: begin ro = tc; go = pc; bo = vc; end
        default:      begin ro = vc; go = pc; bo = qc; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= PIX_W'(ro);
      green_q <= PIX_W'(go);
      blue_q  <= PIX_W'(bo);
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_valid_q <= 1'b0;
      st2_valid_q <= 1'b0;
      st3_valid_q <= 1'b0;
      st4_valid_q <= 1'b0;
      st5_valid_q <= 1'b0;
      st6_valid_q <= 1'b0;
    end else if (en_i) begin
      st1_valid_q <= valid_i;
      st2_valid_q <= st1_valid_q;
      st3_valid_q <= st2_valid_q;
      st4_valid_q <= st3_valid_q;
      st5_valid_q <= st4_valid_q;
      st6_valid_q <= st5_valid_q;
    end
  end

  assign valid_o = st6_valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// ----- rtl/core/hsea_checker.sv -----
module hsea_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [hsea_pkg::PIX_W-1:0]       red_out_o,
  input logic [hsea_pkg::PIX_W-1:0]       green_out_o,
  input logic [hsea_pkg::PIX_W-1:0]       blue_out_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o)
      && $stable(green_out_o) && $stable(blue_out_o))
    else $error("output word changed while stalled");

  // an empty output never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // only output back-pressure stalls the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output drains");

  // register writes are never refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("register write refused");

endmodule

bind hsv_saturation_exposure_adjust_unit hsea_checker u_checker (.*);
